>>> hdl/lrgd_pkg.sv
// Shared types, widths and codes for the linear regression trainer.
// Used by lrgd_div, linear_regression_gradient_descent and the testbench; depends on nothing.
`default_nettype none

package lrgd_pkg;

    localparam int LRGD_MAX_SAMPLES = 1024;
    localparam int LRGD_CNT_W       = $clog2(LRGD_MAX_SAMPLES + 1);

    localparam int SAMPLE_W = 16;
    localparam int FRAC_X   = 12;
    localparam int COEF_W   = 32;
    localparam int RATE_W   = 16;
    localparam int EPOCH_W  = 16;
    localparam int LOSS_W   = 32;
    localparam int STATUS_W = 2;
    localparam int ERR_W    = 38;
    localparam int SUM_W    = 48;
    localparam int ACC_W    = SUM_W + 1;
    localparam int UPD_W    = ACC_W + 1;
    localparam int HALF_W   = 24;
    localparam int HI_W     = ERR_W - HALF_W;
    localparam int SQ_W     = 53;
    localparam int LSUM_W   = 64;
    localparam int DIVD_W   = 64;
    localparam int MUL_A_W  = 25;
    localparam int MUL_B_W  = 49;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;

    localparam int S_TDATA_W = 2 * SAMPLE_W;
    localparam int M_FIELD_W = STATUS_W + 3 * COEF_W + EPOCH_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - M_FIELD_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_WEIGHT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_BIAS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_RATE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EPOCH_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 3'd4;

    localparam logic [RATE_W-1:0]  RST_STEP_RATE   = 16'd655;
    localparam logic [EPOCH_W-1:0] RST_EPOCH_LIMIT = 16'd400;
    localparam logic [LOSS_W-1:0]  RST_THRESHOLD   = 32'd17;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_START = 1'b1;

    localparam logic [STATUS_W-1:0] ST_CONVERGED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_LIMIT      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_SAMPLES = 2'd2;

    localparam logic signed [SUM_W-1:0]  GRAD_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0]  GRAD_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

>>> hdl/lrgd_div.sv
// Iterative unsigned divider, one quotient bit per cycle (restoring).
// Depends on lrgd_pkg for the dividend width and the status struct.
`default_nettype none

module lrgd_div import lrgd_pkg::*; #(
    parameter int DEN_W = LRGD_CNT_W
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               start_i,
    input  wire  [DIVD_W-1:0] dividend_i,
    input  wire  [DEN_W-1:0]  divisor_i,
    output logic [DIVD_W-1:0] quotient_o,
    output div_stat_t         stat_o
);

    localparam int STEP_W = $clog2(DIVD_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg, den_next;

    logic [DEN_W:0] shift_c;
    logic [DEN_W:0] diff_c;
    logic           ge_c;

    assign shift_c = {rem_reg, quo_reg[DIVD_W-1]};
    assign diff_c  = shift_c - {1'b0, den_reg};
    assign ge_c    = (shift_c >= {1'b0, den_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start_i) begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = dividend_i;
            rem_next  = '0;
            den_next  = divisor_i;
        end else if (busy_reg) begin
            rem_next  = ge_c ? diff_c[DEN_W-1:0] : shift_c[DEN_W-1:0];
            quo_next  = {quo_reg[DIVD_W-2:0], ge_c};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(DIVD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg <= step_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign quotient_o  = quo_reg;
    assign stat_o.busy = busy_reg;
    assign stat_o.done = done_reg;

endmodule

`default_nettype wire

>>> hdl/linear_regression_gradient_descent.sv
// Linear regression trainer: fits y = w*x + b by full-batch gradient descent.
// Depends on lrgd_pkg and lrgd_div (shared divider).
//
// Usage:
//   Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes initial
//   weight, initial bias, step rate, epoch limit and convergence threshold.
//   Writes are taken only while no item is in progress.
//   Input items: s_tuser selects load (store one x, y sample) or start.
//   A load produces no result; loads past the store depth are dropped.
//   A start trains on the stored samples, gives one result item on m_*
//   and clears the sample count. Each epoch runs a gradient pass over
//   the samples, two divisions for the weight and bias gradients with
//   their updates, then a loss pass and a loss division; all multiplies
//   run through one multiplier and all divisions through one bit-serial
//   divider under the sequencer. A start with no samples or a zero epoch
//   limit gives its result without training.
//   s_tready is low while training. The result waits in an output
//   register; while m_tready is low the block still takes loads, and a
//   finished run holds until the register is free.
//   Reset (aresetn low, synchronous) clears the sample count, the output
//   and the config registers to their defaults; sample memory is not cleared.
`default_nettype none

module linear_regression_gradient_descent import lrgd_pkg::*; #(
    parameter int MAX_SAMPLES = LRGD_MAX_SAMPLES
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    cfg_valid,
    output logic                   cfg_ready,
    input  wire  [CFG_IDX_W-1:0]   cfg_index,
    input  wire  [CFG_DATA_W-1:0]  cfg_data,
    input  wire                    s_tvalid,
    output logic                   s_tready,
    input  wire  [S_TDATA_W-1:0]   s_tdata,   // sample_x, sample_y
    input  wire                    s_tuser,   // command
    output logic                   m_tvalid,
    input  wire                    m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata    // status, final_weight, final_bias,
                                              // final_loss, epochs_run, zero pad
);

    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_RD    = 5'd1;
    localparam logic [4:0] S_M1    = 5'd2;
    localparam logic [4:0] S_ERR   = 5'd3;
    localparam logic [4:0] S_M2    = 5'd4;
    localparam logic [4:0] S_ACC   = 5'd5;
    localparam logic [4:0] S_GDIV  = 5'd6;
    localparam logic [4:0] S_GWAIT = 5'd7;
    localparam logic [4:0] S_GMUL  = 5'd8;
    localparam logic [4:0] S_GUPD  = 5'd9;
    localparam logic [4:0] S_ABS   = 5'd10;
    localparam logic [4:0] S_HH    = 5'd11;
    localparam logic [4:0] S_HL    = 5'd12;
    localparam logic [4:0] S_LL    = 5'd13;
    localparam logic [4:0] S_SQ    = 5'd14;
    localparam logic [4:0] S_LACC  = 5'd15;
    localparam logic [4:0] S_LDIV  = 5'd16;
    localparam logic [4:0] S_LWAIT = 5'd17;
    localparam logic [4:0] S_CHK   = 5'd18;
    localparam logic [4:0] S_DONE  = 5'd19;

    function automatic logic signed [SUM_W-1:0] sat_acc(input logic [ACC_W-1:0] v);
        logic signed [SUM_W-1:0] r;
        if (v[ACC_W-1] != v[ACC_W-2])
            r = v[ACC_W-1] ? GRAD_MIN : GRAD_MAX;
        else
            r = v[SUM_W-1:0];
        return r;
    endfunction

    // config
    logic signed [COEF_W-1:0] init_w_reg, init_w_next;
    logic signed [COEF_W-1:0] init_b_reg, init_b_next;
    logic [RATE_W-1:0]        rate_reg, rate_next;
    logic [EPOCH_W-1:0]       limit_reg, limit_next;
    logic [LOSS_W-1:0]        thr_reg, thr_next;

    // control
    logic [4:0]        state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              m_tvalid_reg, m_tvalid_next;

    // payload
    logic [CW-1:0]            n_reg, n_next;
    logic [AW-1:0]            idx_reg, idx_next;
    logic                     pass_reg, pass_next;
    logic                     sel_reg, sel_next;
    logic                     neg_reg, neg_next;
    logic signed [COEF_W-1:0] w_reg, w_next;
    logic signed [COEF_W-1:0] b_reg, b_next;
    logic [LOSS_W-1:0]        prev_reg, prev_next;
    logic [LOSS_W-1:0]        loss_reg, loss_next;
    logic [EPOCH_W-1:0]       epoch_reg, epoch_next;
    logic [STATUS_W-1:0]      status_reg, status_next;
    logic signed [SUM_W-1:0]  wsum_reg, wsum_next;
    logic signed [SUM_W-1:0]  bsum_reg, bsum_next;
    logic signed [SUM_W-1:0]  grad_reg, grad_next;
    logic signed [ERR_W-1:0]  err_reg, err_next;
    logic [ERR_W-1:0]         mag_reg, mag_next;
    logic [SQ_W-1:0]          sq_reg, sq_next;
    logic [LSUM_W-1:0]        lsum_reg, lsum_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic [M_TDATA_W-1:0]     m_tdata_reg, m_tdata_next;

    logic [S_TDATA_W-1:0] mem [MAX_SAMPLES];
    logic [S_TDATA_W-1:0] mem_q_reg;

    // datapath
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [SAMPLE_W-1:0] x_val, y_val;
    logic signed [ERR_W-1:0]    err_c;
    logic [ERR_W-1:0]           abs_c;
    logic [HI_W-1:0]            hi_c;
    logic [HALF_W-1:0]          lo_c;
    logic [ACC_W-1:0]           wacc_c, bacc_c;
    logic [ACC_W-1:0]           t_c, tmag_c;
    logic [ACC_W-1:0]           qn_c;
    logic signed [SUM_W-1:0]    grad_c;
    logic signed [UPD_W-1:0]    upd_c;
    logic signed [COEF_W-1:0]   upd_sat_c;
    logic [LSUM_W:0]            lacc_c;
    logic [LOSS_W-1:0]          loss_c, diff_c;
    logic [EPOCH_W-1:0]         epoch_inc;
    logic                       last_c;
    logic                       load_en;
    logic                       div_start;
    logic [DIVD_W-1:0]          div_dividend;
    logic [DIVD_W-1:0]          div_quo;
    div_stat_t                  div_stat;

    assign cfg_ready = (state_reg == S_IDLE);
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign load_en = s_tvalid && s_tready && (s_tuser == CMD_LOAD)
                     && (count_reg < CW'(MAX_SAMPLES));

    assign x_val = signed'(mem_q_reg[SAMPLE_W-1:0]);
    assign y_val = signed'(mem_q_reg[S_TDATA_W-1:SAMPLE_W]);

    assign err_c = ERR_W'(signed'({y_val, {FRAC_X{1'b0}}})) - ERR_W'(b_reg)
                   - ERR_W'(signed'(prod_reg[47:FRAC_X]));
    assign abs_c = err_reg[ERR_W-1] ? ERR_W'(-err_reg) : ERR_W'(err_reg);
    assign hi_c  = mag_reg[ERR_W-1:HALF_W];
    assign lo_c  = mag_reg[HALF_W-1:0];

    assign wacc_c = {wsum_reg[SUM_W-1], wsum_reg} + ACC_W'(signed'(prod_reg[53:FRAC_X]));
    assign bacc_c = {bsum_reg[SUM_W-1], bsum_reg} + ACC_W'(err_reg);

    assign t_c    = sel_reg ? {bsum_reg, 1'b0} : {wsum_reg, 1'b0};
    assign tmag_c = t_c[ACC_W-1] ? (~t_c + ACC_W'(1)) : t_c;
    assign qn_c   = div_quo[ACC_W-1:0];

    always_comb begin
        if (neg_reg)
            grad_c = (qn_c[ACC_W-1:SUM_W-1] != '0) ? GRAD_MAX : signed'(qn_c[SUM_W-1:0]);
        else if (qn_c > {2'b01, {(SUM_W-1){1'b0}}})
            grad_c = GRAD_MIN;
        else
            grad_c = signed'(-qn_c[SUM_W-1:0]);
    end

    assign upd_c = UPD_W'(sel_reg ? b_reg : w_reg) - UPD_W'(signed'(prod_reg[64:16]));
    assign upd_sat_c = ((upd_c[UPD_W-1:COEF_W-1] == '0) || (upd_c[UPD_W-1:COEF_W-1] == '1))
                       ? upd_c[COEF_W-1:0]
                       : (upd_c[UPD_W-1] ? COEF_MIN : COEF_MAX);

    assign lacc_c = {1'b0, lsum_reg} + (LSUM_W + 1)'(sq_reg);
    assign loss_c = (div_quo[DIVD_W-1:LOSS_W] != '0) ? '1 : div_quo[LOSS_W-1:0];
    assign diff_c = (prev_reg > loss_reg) ? (prev_reg - loss_reg) : (loss_reg - prev_reg);
    assign epoch_inc = epoch_reg + EPOCH_W'(1);
    assign last_c = (CW'(idx_reg) == (n_reg - CW'(1)));

    assign div_start    = (state_reg == S_GDIV) || (state_reg == S_LDIV);
    assign div_dividend = (state_reg == S_LDIV) ? lsum_reg : DIVD_W'(tmag_c);

    lrgd_div #(
        .DEN_W(CW)
    ) u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start_i    (div_start),
        .dividend_i (div_dividend),
        .divisor_i  (n_reg),
        .quotient_o (div_quo),
        .stat_o     (div_stat)
    );

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_M1: begin
                mul_a = MUL_A_W'(x_val);
                mul_b = MUL_B_W'(w_reg);
            end
            S_M2: begin
                mul_a = MUL_A_W'(x_val);
                mul_b = MUL_B_W'(err_reg);
            end
            S_HH: begin
                mul_a = MUL_A_W'(hi_c);
                mul_b = MUL_B_W'(hi_c);
            end
            S_HL: begin
                mul_a = MUL_A_W'(lo_c);
                mul_b = MUL_B_W'(hi_c);
            end
            S_LL: begin
                mul_a = MUL_A_W'(lo_c);
                mul_b = MUL_B_W'(lo_c);
            end
            S_GMUL: begin
                mul_a = MUL_A_W'(rate_reg);
                mul_b = MUL_B_W'(grad_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        init_w_next   = init_w_reg;
        init_b_next   = init_b_reg;
        rate_next     = rate_reg;
        limit_next    = limit_reg;
        thr_next      = thr_reg;
        state_next    = state_reg;
        count_next    = count_reg;
        m_tvalid_next = m_tvalid_reg;
        n_next        = n_reg;
        idx_next      = idx_reg;
        pass_next     = pass_reg;
        sel_next      = sel_reg;
        neg_next      = neg_reg;
        w_next        = w_reg;
        b_next        = b_reg;
        prev_next     = prev_reg;
        loss_next     = loss_reg;
        epoch_next    = epoch_reg;
        status_next   = status_reg;
        wsum_next     = wsum_reg;
        bsum_next     = bsum_reg;
        grad_next     = grad_reg;
        err_next      = err_reg;
        mag_next      = mag_reg;
        sq_next       = sq_reg;
        lsum_next     = lsum_reg;
        m_tdata_next  = m_tdata_reg;

        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_INIT_WEIGHT: init_w_next = signed'(cfg_data);
                CFG_INIT_BIAS:   init_b_next = signed'(cfg_data);
                CFG_STEP_RATE:   rate_next   = cfg_data[RATE_W-1:0];
                CFG_EPOCH_LIMIT: limit_next  = cfg_data[EPOCH_W-1:0];
                CFG_THRESHOLD:   thr_next    = cfg_data[LOSS_W-1:0];
                default: ;
            endcase
        end

        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == CMD_LOAD) begin
                        if (load_en)
                            count_next = count_reg + CW'(1);
                    end else begin
                        count_next = '0;
                        n_next     = count_reg;
                        epoch_next = '0;
                        if (count_reg == '0) begin
                            status_next = ST_NO_SAMPLES;
                            w_next      = '0;
                            b_next      = '0;
                            loss_next   = '0;
                            state_next  = S_DONE;
                        end else if (limit_reg == '0) begin
                            status_next = ST_LIMIT;
                            w_next      = init_w_reg;
                            b_next      = init_b_reg;
                            loss_next   = '1;
                            state_next  = S_DONE;
                        end else begin
                            w_next     = init_w_reg;
                            b_next     = init_b_reg;
                            prev_next  = '1;
                            idx_next   = '0;
                            pass_next  = 1'b0;
                            wsum_next  = '0;
                            bsum_next  = '0;
                            state_next = S_RD;
                        end
                    end
                end
            end
            S_RD:  state_next = S_M1;
            S_M1:  state_next = S_ERR;
            S_ERR: begin
                err_next   = err_c;
                state_next = pass_reg ? S_ABS : S_M2;
            end
            S_M2:  state_next = S_ACC;
            S_ACC: begin
                wsum_next = sat_acc(wacc_c);
                bsum_next = sat_acc(bacc_c);
                if (last_c) begin
                    sel_next   = 1'b0;
                    state_next = S_GDIV;
                end else begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = S_RD;
                end
            end
            S_GDIV: begin
                neg_next   = t_c[ACC_W-1];
                state_next = S_GWAIT;
            end
            S_GWAIT: begin
                if (div_stat.done) begin
                    grad_next  = grad_c;
                    state_next = S_GMUL;
                end
            end
            S_GMUL: state_next = S_GUPD;
            S_GUPD: begin
                if (sel_reg) begin
                    b_next     = upd_sat_c;
                    idx_next   = '0;
                    pass_next  = 1'b1;
                    lsum_next  = '0;
                    state_next = S_RD;
                end else begin
                    w_next     = upd_sat_c;
                    sel_next   = 1'b1;
                    state_next = S_GDIV;
                end
            end
            S_ABS: begin
                mag_next   = abs_c;
                state_next = S_HH;
            end
            S_HH: state_next = S_HL;
            S_HL: begin
                sq_next    = SQ_W'(prod_reg[2*HI_W-1:0]) << HALF_W;
                state_next = S_LL;
            end
            S_LL: begin
                sq_next    = sq_reg + SQ_W'({prod_reg[HI_W+HALF_W-1:0], 1'b0});
                state_next = S_SQ;
            end
            S_SQ: begin
                sq_next    = sq_reg + SQ_W'(prod_reg[2*HALF_W-1:HALF_W]);
                state_next = S_LACC;
            end
            S_LACC: begin
                lsum_next = lacc_c[LSUM_W] ? '1 : lacc_c[LSUM_W-1:0];
                if (last_c) begin
                    state_next = S_LDIV;
                end else begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = S_RD;
                end
            end
            S_LDIV: state_next = S_LWAIT;
            S_LWAIT: begin
                if (div_stat.done) begin
                    loss_next  = loss_c;
                    state_next = S_CHK;
                end
            end
            S_CHK: begin
                epoch_next = epoch_inc;
                if ((epoch_reg != '0) && (diff_c < thr_reg)) begin
                    status_next = ST_CONVERGED;
                    state_next  = S_DONE;
                end else begin
                    prev_next = loss_reg;
                    if (epoch_inc < limit_reg) begin
                        idx_next   = '0;
                        pass_next  = 1'b0;
                        wsum_next  = '0;
                        bsum_next  = '0;
                        state_next = S_RD;
                    end else begin
                        status_next = ST_LIMIT;
                        state_next  = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{M_PAD_W{1'b0}}, epoch_reg, loss_reg, b_reg, w_reg,
                                     status_reg};
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_w_reg   <= '0;
            init_b_reg   <= '0;
            rate_reg     <= RST_STEP_RATE;
            limit_reg    <= RST_EPOCH_LIMIT;
            thr_reg      <= RST_THRESHOLD;
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            init_w_reg   <= init_w_next;
            init_b_reg   <= init_b_next;
            rate_reg     <= rate_next;
            limit_reg    <= limit_next;
            thr_reg      <= thr_next;
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg       <= n_next;
        idx_reg     <= idx_next;
        pass_reg    <= pass_next;
        sel_reg     <= sel_next;
        neg_reg     <= neg_next;
        w_reg       <= w_next;
        b_reg       <= b_next;
        prev_reg    <= prev_next;
        loss_reg    <= loss_next;
        epoch_reg   <= epoch_next;
        status_reg  <= status_next;
        wsum_reg    <= wsum_next;
        bsum_reg    <= bsum_next;
        grad_reg    <= grad_next;
        err_reg     <= err_next;
        mag_reg     <= mag_next;
        sq_reg      <= sq_next;
        lsum_reg    <= lsum_next;
        prod_reg    <= mul_a * mul_b;
        m_tdata_reg <= m_tdata_next;
    end

    always_ff @(posedge aclk) begin
        if (load_en)
            mem[count_reg[AW-1:0]] <= s_tdata;
        mem_q_reg <= mem[idx_reg];
    end

    a_div_done_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == S_GWAIT || state_reg == S_LWAIT))
        else $error("divider finished outside a wait state");

    a_div_start_free: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    a_epoch_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE && state_reg != S_DONE) |-> (epoch_reg < limit_reg))
        else $error("epoch counter reached limit during training");

    a_start_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == CMD_START) |=> (count_reg == '0))
        else $error("sample count not cleared by start");

endmodule

`default_nettype wire

>>> dv/tb_linear_regression_gradient_descent.sv
// Testbench for linear_regression_gradient_descent: drives sample loads, starts and
// register writes, predicts each training result in a scoreboard and checks every item.
// Depends on lrgd_pkg and the trainer RTL only.

module tb_linear_regression_gradient_descent;
    import lrgd_pkg::*;

    localparam int ITEMS       = 2000;
    localparam int MIN_STARTS  = 60;
    localparam int HOLD_CYCLES = 3000;

    localparam longint S48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint S48_MIN = -S48_MAX - 1;
    localparam longint C32_MAX = 64'sd2147483647;
    localparam longint C32_MIN = -64'sd2147483648;
    localparam longint LOSS_SAT = 64'hFFFF_FFFF;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [COEF_W-1:0]   weight;
        logic [COEF_W-1:0]   bias;
        logic [LOSS_W-1:0]   loss;
        logic [EPOCH_W-1:0]  epochs;
    } fit_result_t;

    class fit_scoreboard;
        shortint     xs[$];
        shortint     ys[$];
        int          init_w = 0;
        int          init_b = 0;
        int          rate = RST_STEP_RATE;
        int          limit = RST_EPOCH_LIMIT;
        longint      thr = RST_THRESHOLD;
        fit_result_t expected_fits[$];
        int          mismatches = 0;

        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_INIT_WEIGHT: init_w = int'(data);
                CFG_INIT_BIAS:   init_b = int'(data);
                CFG_STEP_RATE:   rate = int'(data[RATE_W-1:0]);
                CFG_EPOCH_LIMIT: limit = int'(data[EPOCH_W-1:0]);
                CFG_THRESHOLD:   thr = longint'(data);
                default: ;
            endcase
        endfunction

        function longint sat(longint v, longint lo, longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        // residual in Q.12: y - (w*x + b)
        function longint resid(int i, longint w, longint b);
            return longint'(ys[i]) * 4096 - ((w * longint'(xs[i])) >>> 12) - b;
        endfunction

        function int pending();
            return expected_fits.size();
        endfunction

        function void note_item(logic cmd, logic [15:0] x, logic [15:0] y);
            fit_result_t r;
            longint w, b, sw, sbias, gw, gb, e, loss, prev, diff, n;
            longint unsigned m, hi, lo, acc, sq;
            int epochs;
            if (cmd == CMD_LOAD) begin
                if (xs.size() < LRGD_MAX_SAMPLES) begin
                    xs.push_back(shortint'(x));
                    ys.push_back(shortint'(y));
                end
                return;
            end
            n = xs.size();
            r.status = ST_NO_SAMPLES;
            r.weight = '0;
            r.bias = '0;
            r.loss = '0;
            r.epochs = '0;
            if (n != 0) begin
                w = init_w;
                b = init_b;
                prev = LOSS_SAT;
                loss = LOSS_SAT;
                epochs = 0;
                r.status = ST_LIMIT;
                while (epochs < limit) begin
                    sw = 0;
                    sbias = 0;
                    for (int i = 0; i < n; i++) begin
                        e = resid(i, w, b);
                        sw = sat(sw + ((longint'(xs[i]) * e) >>> 12), S48_MIN, S48_MAX);
                        sbias = sat(sbias + e, S48_MIN, S48_MAX);
                    end
                    gw = sat(-((2 * sw) / n), S48_MIN, S48_MAX);
                    gb = sat(-((2 * sbias) / n), S48_MIN, S48_MAX);
                    w = sat(w - ((rate * gw) >>> 16), C32_MIN, C32_MAX);
                    b = sat(b - ((rate * gb) >>> 16), C32_MIN, C32_MAX);
                    acc = 0;
                    for (int i = 0; i < n; i++) begin
                        e = resid(i, w, b);
                        m = (e < 0) ? -e : e;
                        hi = m >> 24;
                        lo = m & 64'hFF_FFFF;
                        sq = ((hi * hi) << 24) + 2 * hi * lo + ((lo * lo) >> 24);
                        acc = (acc + sq < acc) ? '1 : acc + sq;
                    end
                    acc = acc / n;
                    loss = (acc > LOSS_SAT) ? LOSS_SAT : longint'(acc);
                    epochs++;
                    diff = (prev > loss) ? prev - loss : loss - prev;
                    if (epochs > 1 && diff < thr) begin
                        r.status = ST_CONVERGED;
                        break;
                    end
                    prev = loss;
                end
                r.weight = w[COEF_W-1:0];
                r.bias = b[COEF_W-1:0];
                r.loss = loss[LOSS_W-1:0];
                r.epochs = 16'(epochs);
            end
            expected_fits.push_back(r);
            xs.delete();
            ys.delete();
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] d);
            fit_result_t got, want;
            got.status = d[0 +: STATUS_W];
            got.weight = d[STATUS_W +: COEF_W];
            got.bias = d[STATUS_W + COEF_W +: COEF_W];
            got.loss = d[STATUS_W + 2 * COEF_W +: LOSS_W];
            got.epochs = d[STATUS_W + 2 * COEF_W + LOSS_W +: EPOCH_W];
            if (expected_fits.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result item: %h", d);
                mismatches++;
                return;
            end
            want = expected_fits.pop_front();
            if (got.status !== want.status || got.weight !== want.weight ||
                got.bias !== want.bias || got.loss !== want.loss ||
                got.epochs !== want.epochs) begin
                if (mismatches < 10)
                    $display("fit mismatch (exp/got): status %0d/%0d weight %h/%h bias %h/%h",
                             want.status, got.status, want.weight, got.weight,
                             want.bias, got.bias,
                             " loss %h/%h epochs %0d/%0d",
                             want.loss, got.loss, want.epochs, got.epochs);
                mismatches++;
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // sample_x, sample_y
    logic                  s_tuser;   // command
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;   // status, final_weight, final_bias,
                                      // final_loss, epochs_run, zero pad

    fit_scoreboard sb;
    int src_idle_pct;
    int sink_idle_pct;
    int stall_seq;
    int items_sent;
    int starts_sent;

    linear_regression_gradient_descent dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_item(s_tuser, s_tdata[15:0], s_tdata[31:16]);
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // receiver: random backpressure, or a long hold when requested
    initial begin
        int seen;
        seen = 0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_seq != seen) begin
                seen = stall_seq;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    initial begin
        #80_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic send_item(logic cmd, logic [15:0] x, logic [15:0] y);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {y, x};
        s_tuser <= cmd;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        if (cmd == CMD_START)
            starts_sent++;
    endtask

    task automatic load_set(int n, bit on_line);
        int sl, off, x, y;
        sl = int'($urandom_range(0, 16383)) - 8192;
        off = int'($urandom_range(0, 16383)) - 8192;
        repeat (n) begin
            if (on_line) begin
                x = int'($urandom_range(0, 32767)) - 16384;
                y = ((sl * x) >>> 12) + off + int'($urandom_range(0, 511)) - 256;
                if (y > 32767)
                    y = 32767;
                else if (y < -32768)
                    y = -32768;
            end else begin
                x = $urandom;
                y = $urandom;
            end
            send_item(CMD_LOAD, x[15:0], y[15:0]);
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.apply_reg(idx, data);
    endtask

    task automatic set_training(logic [31:0] w, logic [31:0] b, logic [15:0] rate,
                                logic [15:0] limit, logic [31:0] thr);
        write_reg(CFG_INIT_WEIGHT, w);
        write_reg(CFG_INIT_BIAS, b);
        write_reg(CFG_STEP_RATE, {16'h0, rate});
        write_reg(CFG_EPOCH_LIMIT, {16'h0, limit});
        write_reg(CFG_THRESHOLD, thr);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_coef();
        int pick;
        pick = $urandom_range(9);
        if (pick < 6)
            return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
        if (pick < 8)
            return $urandom;
        return (pick == 8) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endfunction

    initial begin
        int grp, n, pick;
        logic [31:0] w, b, thr;
        logic [15:0] rate;
        sb = new();
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_LOAD;
        src_idle_pct = 19;
        sink_idle_pct = 66;
        stall_seq = 0;
        items_sent = 0;
        starts_sent = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // start with an empty store, then a small fit at reset settings
        send_item(CMD_START, 16'h0, 16'h0);
        send_item(CMD_LOAD, 16'h1000, 16'h2000);
        send_item(CMD_LOAD, 16'hF000, 16'h0000);
        send_item(CMD_LOAD, 16'h2000, 16'h3000);
        send_item(CMD_START, 16'h0, 16'h0);

        wait_idle();
        set_training(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 16'd3, 32'h0);
        send_item(CMD_LOAD, 16'h7FFF, 16'h8000);
        send_item(CMD_LOAD, 16'h8000, 16'h7FFF);
        send_item(CMD_LOAD, 16'h0000, 16'h0000);
        send_item(CMD_START, 16'hFFFF, 16'hFFFF);

        wait_idle();
        set_training(32'h8000_0000, 32'h7FFF_FFFF, 16'h0, 16'd2, 32'h0);
        send_item(CMD_LOAD, 16'h8000, 16'h8000);
        send_item(CMD_LOAD, 16'h7FFF, 16'h7FFF);
        send_item(CMD_START, 16'h0, 16'h0);

        // no epochs at all
        wait_idle();
        set_training(32'h0, 32'h0, 16'd655, 16'd0, 32'd17);
        send_item(CMD_LOAD, 16'h1000, 16'h1000);
        send_item(CMD_START, 16'h0, 16'h0);

        // widest epoch limit; a loss change below the all-ones threshold ends it on the second epoch
        wait_idle();
        set_training(32'h0100_0000, 32'h0, 16'd655, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(CMD_LOAD, 16'h1000, 16'h2000);
        send_item(CMD_LOAD, 16'h2000, 16'h3000);
        send_item(CMD_START, 16'h0, 16'h0);

        // overfill the sample store
        wait_idle();
        set_training(pick_coef(), 32'h0, 16'd655, 16'd2, 32'd17);
        load_set(LRGD_MAX_SAMPLES + 6, 1'b0);
        send_item(CMD_START, 16'h0, 16'h0);

        // long receiver hold while starts keep coming
        wait_idle();
        set_training(32'h0, 32'h0, 16'd2000, 16'd2, 32'h0);
        stall_seq++;
        repeat (4) begin
            load_set(2, 1'b1);
            send_item(CMD_START, 16'h0, 16'h0);
        end

        grp = 0;
        while (items_sent < ITEMS || starts_sent < MIN_STARTS) begin
            if (starts_sent >= 45) begin
                src_idle_pct = 0;
                sink_idle_pct = 0;
            end else if (starts_sent >= 25) begin
                src_idle_pct = 66;
                sink_idle_pct = 19;
            end
            if (grp % 8 == 0) begin
                wait_idle();
                w = pick_coef();
                b = pick_coef();
                pick = $urandom_range(9);
                if (pick < 7)
                    rate = $urandom_range(100, 4000);
                else if (pick == 7)
                    rate = 16'h0;
                else if (pick == 8)
                    rate = 16'hFFFF;
                else
                    rate = $urandom;
                pick = $urandom_range(9);
                if (pick < 4)
                    thr = $urandom_range(0, 4096);
                else if (pick < 6)
                    thr = 32'h0;
                else if (pick < 8)
                    thr = $urandom;
                else
                    thr = 32'hFFFF_FFFF;
                set_training(w, b, rate, 16'($urandom_range(1, 12)), thr);
            end
            pick = $urandom_range(99);
            if (pick < 3)
                n = 0;
            else if (pick < 88)
                n = $urandom_range(1, 24);
            else
                n = $urandom_range(25, 120);
            load_set(n, $urandom_range(99) < 60);
            send_item(CMD_START, $urandom, $urandom);
            grp++;
        end

        wait_idle();
        repeat (100) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
